// File: rtl/core/skf_pkg.sv
// types and constants of the scalar kalman filter
package skf_pkg;

    localparam int unsigned GAIN_BITS = 16;
    localparam logic [16:0] GAIN_ONE  = 17'h10000;
    localparam int unsigned STEPS     = 17;

    localparam logic [1:0] CFG_PROCESS_NOISE     = 2'd0;
    localparam logic [1:0] CFG_MEASUREMENT_NOISE = 2'd1;
    localparam logic [1:0] CFG_INITIAL_ESTIMATE  = 2'd2;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PRED = 7'b0000010,
        S_DEN  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_GAIN = 7'b0010000,
        S_MUL  = 7'b0100000,
        S_UPD  = 7'b1000000
    } t_state;

endpackage

// File: rtl/core/scalar_kalman_filter_unit.sv
// one-dimensional kalman filter on a stream of signed fixed-point measurements
//
// usage
//   input items arrive on s_axis: tdata is the signed measurement, tuser the
//   restart flag. results leave on m_axis: tdata holds the estimate in bits
//   31:0 and the gain (q1.16, 65536 is 1.0) in bits 48:32.
//   the user must write noise variances and the restart estimate on the cfg
//   port while idle only (not enforced); index 0 q, 1 r, 2 initial estimate.
// processing
//   an update item passes from acceptance to the output register through the
//   predict step, the denominator step, 17 steps of the bit-serial restoring
//   divider, the gain step, 17 steps of two shift-add multipliers running
//   side by side, and the update step. a restart item goes straight to update.
//   s_axis_tready is high again once the result is in the output register,
//   so the next item is taken only after the last one is through.
// reset
//   synchronous, active low: registers go to q = 66, r = 65536, initial
//   estimate 0, estimate 0 and covariance 1.0.
// stall
//   one result waits in the output register while the next item is taken;
//   a second finished result holds in the update step until it drains.
module scalar_kalman_filter_unit
    import skf_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // measurement[31:0]
    input  logic        s_axis_tuser,   // restart[0]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // estimate[31:0], gain[48:32], zero fill
);

    // covariance value 1.0 in the data format
    localparam logic [31:0] COV_ONE = 32'(64'd1 << FRAC_BITS);

    t_state      r_state, n_state;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_restart, n_restart;

    // configuration registers
    logic [30:0] r_q, n_q;
    logic [30:0] r_r, n_r;
    logic [31:0] r_x0, n_x0;

    // filter state
    logic [31:0] r_est, n_est;
    logic [31:0] r_cov, n_cov;

    // working registers
    logic [32:0] r_diff, n_diff;   // measurement, then m - x
    logic [31:0] r_p1, n_p1;       // predicted covariance
    logic [32:0] r_den, n_den;     // p1 + r
    logic [33:0] r_rem, n_rem;     // divider remainder
    logic [16:0] r_quo, n_quo;     // divider quotient bits
    logic [16:0] r_k, n_k;         // gain of this item
    logic [50:0] r_pa, n_pa;       // (m - x) * k, multiplier bits in the low end
    logic [49:0] r_pb, n_pb;       // (1 - k) * p1, same layout

    // output register
    logic        r_out_valid, n_out_valid;
    logic [55:0] r_out_data, n_out_data;

    logic [32:0] w_pq;
    logic [32:0] w_den_sum;
    logic        w_ge;
    logic [33:0] w_rsub;
    logic [33:0] w_sa;
    logic [33:0] w_sb;
    logic [35:0] w_xsum;
    logic [31:0] w_xsat;
    logic [33:0] w_pnew;
    logic [16:0] w_kgain;
    logic        w_out_free;
    logic        w_commit;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_commit   = (r_state == S_UPD) && w_out_free;

    // predict: p + q, saturated later
    assign w_pq      = {1'b0, r_cov} + {2'b0, r_q};
    assign w_den_sum = {1'b0, r_p1} + {2'b0, r_r};

    // one restoring division step
    assign w_ge   = (r_rem >= {1'b0, r_den});
    assign w_rsub = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;

    // one shift-add step of each multiplier
    assign w_sa = r_pa[50:17] + (r_pa[0] ? {r_diff[32], r_diff} : 34'd0);
    assign w_sb = {1'b0, r_pb[49:17]} + (r_pb[0] ? {2'b0, r_p1} : 34'd0);

    // x + round(d / 65536), rounding bit enters as a carry
    assign w_xsum = {{4{r_est[31]}}, r_est} + {r_pa[50], r_pa[50:16]}
                    + {35'd0, r_pa[15]};
    assign w_xsat = (w_xsum[35:31] == 5'b00000 || w_xsum[35:31] == 5'b11111)
                    ? w_xsum[31:0]
                    : (w_xsum[35] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    assign w_pnew = r_pb[49:16] + {33'd0, r_pb[15]};

    // zero denominator gives gain 1.0
    assign w_kgain = (r_den == 33'd0) ? GAIN_ONE
                   : ((r_quo > GAIN_ONE) ? GAIN_ONE : r_quo);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_restart   = r_restart;
        n_q         = r_q;
        n_r         = r_r;
        n_x0        = r_x0;
        n_est       = r_est;
        n_cov       = r_cov;
        n_diff      = r_diff;
        n_p1        = r_p1;
        n_den       = r_den;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_k         = r_k;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_PROCESS_NOISE:     n_q  = i_cfg_wdata[30:0];
                CFG_MEASUREMENT_NOISE: n_r  = i_cfg_wdata[30:0];
                CFG_INITIAL_ESTIMATE:  n_x0 = i_cfg_wdata;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_restart = s_axis_tuser;
                    n_diff    = {s_axis_tdata[31], s_axis_tdata};
                    n_state   = s_axis_tuser ? S_UPD : S_PRED;
                end
            end
            S_PRED: begin
                n_p1    = w_pq[32] ? 32'hFFFF_FFFF : w_pq[31:0];
                n_diff  = r_diff - {r_est[31], r_est};
                n_state = S_DEN;
            end
            S_DEN: begin
                n_den   = w_den_sum;
                n_rem   = {2'b0, r_p1};
                n_quo   = 17'd0;
                n_cnt   = 5'd0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_quo = {r_quo[15:0], w_ge};
                n_rem = {w_rsub[32:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(STEPS - 1)) begin
                    n_state = S_GAIN;
                end
            end
            S_GAIN: begin
                n_k     = w_kgain;
                n_pa    = {34'd0, w_kgain};
                n_pb    = {33'd0, GAIN_ONE - w_kgain};
                n_cnt   = 5'd0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_pa  = {w_sa[33], w_sa, r_pa[16:1]};
                n_pb  = {w_sb, r_pb[16:1]};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(STEPS - 1)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_restart) begin
                        n_est      = r_x0;
                        n_cov      = COV_ONE;
                        n_out_data = {7'd0, 17'd0, r_x0};
                    end else begin
                        n_est      = w_xsat;
                        n_cov      = w_pnew[31:0];
                        n_out_data = {7'd0, r_k, w_xsat};
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 5'd0;
            r_restart   <= 1'b0;
            r_q         <= 31'd66;
            r_r         <= 31'd65536;
            r_x0        <= 32'd0;
            r_est       <= 32'd0;
            r_cov       <= COV_ONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_restart   <= n_restart;
            r_q         <= n_q;
            r_r         <= n_r;
            r_x0        <= n_x0;
            r_est       <= n_est;
            r_cov       <= n_cov;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff     <= n_diff;
        r_p1       <= n_p1;
        r_den      <= n_den;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_k        <= n_k;
        r_pa       <= n_pa;
        r_pb       <= n_pb;
        r_out_data <= n_out_data;
    end

    // gain on the output never exceeds 1.0
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[48:32] <= GAIN_ONE))
        else $error("gain above 1.0 on output");

    // divider remainder stays no higher than twice the denominator
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem <= {r_den, 1'b0}))
        else $error("divider remainder out of range");

    // an update never grows the covariance beyond its prediction
    a_cov_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && !r_restart) |=> (r_cov <= $past(r_p1)))
        else $error("covariance grew in update");

    // a restart delivers zero gain and the loaded estimate
    a_restart_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_restart) |=>
            (m_axis_tvalid && m_axis_tdata[48:32] == 17'd0
             && m_axis_tdata[31:0] == $past(r_x0)))
        else $error("restart result wrong");

    // no new item is taken while a finished result is stuck in the update step
    a_hold_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_UPD) && !w_out_free) |=> (r_state == S_UPD))
        else $error("update step left while output busy");

endmodule
